>>> rtl/pic_pkg.sv
// Shared types, codes and constants of the priority interrupt controller.
package pic_pkg;

    // Operation codes of an input item
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RAISE = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // Register numbers on the bus
    localparam logic [2:0] REG_VECTOR = 3'd0;
    localparam logic [2:0] REG_ENABLE = 3'd1;
    localparam logic [2:0] REG_CLR_EN = 3'd2;
    localparam logic [2:0] REG_SET_EN = 3'd3;
    localparam logic [2:0] REG_EDGE   = 3'd4;
    localparam logic [2:0] REG_ACK    = 3'd5;

    // Vector base and the lines that carry a request flag
    localparam logic [7:0] VEC_BASE  = 8'd192;
    localparam int         NUM_FLAGS = 4;
    localparam logic [3:0] FLAG_LINE [NUM_FLAGS] = '{4'd1, 4'd2, 4'd3, 4'd7};

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  register_select;
        logic [15:0] write_data;
        logic [3:0]  raise_line;
    } t_in_item;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq_active;
        logic [7:0]  vector_number;
    } t_out_item;

    typedef struct packed {
        logic [15:0]          enable;
        logic [15:0]          edge_mode;
        logic [NUM_FLAGS-1:0] pending;
        logic [7:0]           vector;
        logic                 irq;
    } t_state;

    typedef struct packed {
        logic       irq;
        logic [7:0] vector;
    } t_eval;

    // Map a line number to its request flag; lines without a flag give zero
    function automatic logic [NUM_FLAGS-1:0] line_flag(input logic [15:0] line);
        logic [NUM_FLAGS-1:0] flag;
        flag = '0;
        for (int k = 0; k < NUM_FLAGS; k++) begin
            if (line == {12'd0, FLAG_LINE[k]}) begin
                flag[k] = 1'b1;
            end
        end
        return flag;
    endfunction

endpackage

>>> rtl/pic_stream_if.sv
// Valid/ready channel interface carrying one item of a given payload type.
interface pic_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/priority_interrupt_controller_core.sv
// Top level of the priority interrupt controller: input register, state, result register.
//
// Each request item is one of four operations: a bus read, a bus write, a
// raise of a request line, or a tick that re-evaluates the interrupt. An item
// is captured in an input register, processed combinationally against the
// controller state, and its result lands in an output register. The block takes
// one item per clock cycle while results are taken; the result becomes valid when
// the item moves from the input register into the result register. A result that
// is not taken stalls the pipeline, and i_req.ready then follows o_rsp.ready.
// Only lines 1, 2, 3 and 7 carry request flags; vector and irq change on a tick.
module priority_interrupt_controller_core
    import pic_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    pic_stream_if.sink   i_req,
    pic_stream_if.source o_rsp
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      w_adv;
    t_state    w_next;

    // Advance the item in the input register when the result slot frees up
    assign w_adv       = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_adv;

    pic_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_adv),
        .i_item  (r_in),
        .o_next  (w_next)
    );

    // Form the result from the state after the operation
    always_comb begin
        n_out.read_data     = '0;
        n_out.irq_active    = w_next.irq;
        n_out.vector_number = w_next.vector;
        if (r_in.operation == OP_READ) begin
            n_out.read_data = (r_in.register_select == REG_VECTOR) ?
                              {8'd0, w_next.vector} : w_next.enable;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
        if (i_req.ready && i_req.valid) begin
            r_in <= i_req.payload;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // irq is high exactly when the vector is off the base
    a_irq_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.irq_active == (r_out.vector_number != VEC_BASE)))
        else $error("irq and vector disagree");

    // Only a tick may move the vector
    a_vec_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.operation != OP_TICK) |-> (w_next.vector == r_out.vector_number
            || !r_out_valid || $past(!i_rst_n)))
        else $error("vector changed outside a tick");

    // A non-read result carries zero read data
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.operation != OP_READ) |=> (r_out.read_data == 16'd0))
        else $error("read data on a non-read item");

endmodule

>>> rtl/pic_prio.sv
// Priority evaluator: lowest enabled pending line wins.
module pic_prio
    import pic_pkg::*;
(
    input  logic [15:0]          i_enable,
    input  logic [NUM_FLAGS-1:0] i_pending,
    output t_eval                o_eval
);

    // Scan from the highest flag down so the lowest line is taken last
    always_comb begin
        o_eval.irq    = 1'b0;
        o_eval.vector = VEC_BASE;
        for (int k = NUM_FLAGS - 1; k >= 0; k--) begin
            if (i_pending[k] && i_enable[FLAG_LINE[k]]) begin
                o_eval.irq    = 1'b1;
                o_eval.vector = VEC_BASE + {4'd0, FLAG_LINE[k]};
            end
        end
    end

endmodule

>>> rtl/pic_regs.sv
// Controller state: enable and edge masks, request flags, vector and irq.
module pic_regs
    import pic_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_upd,
    input  t_in_item i_item,
    output t_state   o_next
);

    t_state r_state;
    t_state n_state;
    t_eval  w_eval;

    pic_prio u_prio (
        .i_enable  (r_state.enable),
        .i_pending (r_state.pending),
        .o_eval    (w_eval)
    );

    // Apply one operation to the held state
    always_comb begin
        n_state = r_state;
        case (i_item.operation)
            OP_WRITE: begin
                case (i_item.register_select)
                    REG_ENABLE: n_state.enable = i_item.write_data;
                    REG_CLR_EN: n_state.enable[i_item.write_data[3:0]] = 1'b0;
                    REG_SET_EN: n_state.enable[i_item.write_data[3:0]] = 1'b1;
                    REG_EDGE:   n_state.edge_mode = i_item.write_data;
                    REG_ACK:    n_state.pending =
                                    r_state.pending & ~line_flag(i_item.write_data);
                    default:    n_state = r_state;
                endcase
            end
            OP_RAISE: begin
                n_state.pending = r_state.pending | line_flag({12'd0, i_item.raise_line});
            end
            OP_TICK: begin
                n_state.irq    = w_eval.irq;
                n_state.vector = w_eval.vector;
            end
            default: n_state = r_state;
        endcase
    end

    // Hold state; advance when an item is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.enable    <= '0;
            r_state.edge_mode <= '0;
            r_state.pending   <= '0;
            r_state.vector    <= VEC_BASE;
            r_state.irq       <= 1'b0;
        end else if (i_upd) begin
            r_state <= n_state;
        end
    end

    assign o_next = n_state;

endmodule
